/* sv/ppm_frame_decoder_macros.svh */
// Assertion macros used by the decoder controller module.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PPM_FRAME_DECODER_MACROS_SVH
`define PPM_FRAME_DECODER_MACROS_SVH

// Same-cycle implication.
`define PPMFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPMFD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ppmfd_pkg.sv */
// ----------------------------------------------------------------------------
// ppmfd_pkg
// Types and constants shared by the pulse-position frame decoder modules.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    localparam int VAL_W     = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_END_GAP    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [VAL_W-1:0] RST_MIN_PULSE  = VAL_W'(700);
    localparam logic [VAL_W-1:0] RST_MAX_PULSE  = VAL_W'(2300);
    localparam logic [VAL_W-1:0] RST_END_GAP    = VAL_W'(2500);
    localparam logic [VAL_W-1:0] RST_TIMEOUT_MS = VAL_W'(1000);

    // Result kinds
    localparam logic KIND_CHANNEL = 1'b0;
    localparam logic KIND_STOP    = 1'b1;

    typedef struct packed {
        logic capture_edge;
        logic ms_tick;
    } t_in_item;

    typedef struct packed {
        logic             kind;
        logic [2:0]       channel_index;
        logic [VAL_W-1:0] channel_value;
        logic [3:0]       frame_channels;
        logic             locked;
        logic             last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic step;
        logic load_slot;
        logic load_stop;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic item_stop;
        logic item_report;
        logic out_free;
        logic idx_last;
    } t_dp_status;

endpackage

/* sv/ppmfd_ctrl.sv */
// ----------------------------------------------------------------------------
// ppmfd_ctrl
// Controller: accepts ticks, sequences the frame report burst and the stop
// result, and holds the halted state.
// ----------------------------------------------------------------------------
`include "ppm_frame_decoder_macros.svh"

module ppmfd_ctrl
    import ppmfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BURST = 4'b0010,
        S_STOP  = 4'b0100,
        S_HALT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   step;

    assign o_in_stall = !((r_state == S_IDLE) || (r_state == S_HALT));
    assign step       = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.step      = step;
        unique case (r_state)
            S_IDLE: begin
                if (step && i_status.item_stop) begin
                    n_state = S_STOP;
                end else if (step && i_status.item_report) begin
                    n_state = S_BURST;
                end
            end
            S_BURST: begin
                if (i_status.out_free) begin
                    o_cmd.load_slot = 1'b1;
                    if (i_status.idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_STOP: begin
                if (i_status.out_free) begin
                    o_cmd.load_stop = 1'b1;
                    n_state         = S_HALT;
                end
            end
            S_HALT: begin
                // drop every request until reset
                n_state = S_HALT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PPMFD_ASSERT_NXT(a_stop_next, step && i_status.item_stop, r_state == S_STOP, "stop not taken")
    `PPMFD_ASSERT_NXT(a_burst_next, step && i_status.item_report && !i_status.item_stop, r_state == S_BURST, "burst not started")
    `PPMFD_ASSERT_NXT(a_burst_end, o_cmd.load_slot && i_status.idx_last, r_state == S_IDLE, "burst overran")
    `PPMFD_ASSERT_NXT(a_halt_hold, r_state == S_HALT, (r_state == S_HALT) && !o_cmd.load_slot && !o_cmd.load_stop, "left halt")

endmodule

/* sv/ppmfd_datapath.sv */
// ----------------------------------------------------------------------------
// ppmfd_datapath
// Datapath: configuration registers, gap and millisecond counters, frame
// tracking, channel slot store and the output register.
// ----------------------------------------------------------------------------
module ppmfd_datapath
    import ppmfd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data,
    input  t_in_item             i_in_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    localparam int CH_W  = $clog2(NUM_CHANNELS + 1);
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W-1:0]  CH_FULL  = CH_W'(NUM_CHANNELS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);

    logic [VAL_W-1:0] r_min_pulse;
    logic [VAL_W-1:0] r_max_pulse;
    logic [VAL_W-1:0] r_end_gap;
    logic [VAL_W-1:0] r_timeout_ms;

    logic [VAL_W-1:0] r_gap_count, n_gap_count;
    logic [VAL_W-1:0] r_ms_count,  n_ms_count;
    logic             r_in_frame,  n_in_frame;
    logic             r_gap_seen,  n_gap_seen;
    logic [CH_W-1:0]  r_next_ch,   n_next_ch;
    logic             r_lock,      n_lock;
    logic [CH_W-1:0]  r_frame_ch;
    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_store [NUM_CHANNELS];
    logic             r_out_valid;
    t_out_item        r_out;

    logic [VAL_W-1:0] ms_inc;
    logic [VAL_W-1:0] gap_inc;
    logic             stop;
    logic             sync;
    logic             report;
    logic             in_frame_mid;
    logic             gap_seen_mid;
    logic             store_we;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pulse  <= RST_MIN_PULSE;
            r_max_pulse  <= RST_MAX_PULSE;
            r_end_gap    <= RST_END_GAP;
            r_timeout_ms <= RST_TIMEOUT_MS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_PULSE:  r_min_pulse  <= i_cfg_data;
                CFG_MAX_PULSE:  r_max_pulse  <= i_cfg_data;
                CFG_END_GAP:    r_end_gap    <= i_cfg_data;
                CFG_TIMEOUT_MS: r_timeout_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-tick frame tracking
    always_comb begin
        ms_inc  = (i_in_data.ms_tick && (r_ms_count != VAL_MAX)) ?
                  r_ms_count + VAL_W'(1) : r_ms_count;
        stop    = ms_inc > r_timeout_ms;
        gap_inc = (r_gap_count != VAL_MAX) ? r_gap_count + VAL_W'(1) : r_gap_count;
        sync    = gap_inc > r_end_gap;
        report  = sync && r_in_frame && (r_next_ch != '0);

        in_frame_mid = report ? 1'b0 : r_in_frame;
        gap_seen_mid = sync | r_gap_seen;

        n_ms_count  = r_ms_count;
        n_gap_count = r_gap_count;
        n_in_frame  = r_in_frame;
        n_gap_seen  = r_gap_seen;
        n_next_ch   = r_next_ch;
        n_lock      = r_lock;
        store_we    = 1'b0;

        if (i_cmd.step) begin
            n_ms_count = ms_inc;
            if (!stop) begin
                n_gap_count = gap_inc;
                n_in_frame  = in_frame_mid;
                n_gap_seen  = gap_seen_mid;
                if (report) begin
                    n_lock     = 1'b1;
                    n_ms_count = '0;
                end
                if (i_in_data.capture_edge) begin
                    if (!in_frame_mid) begin
                        if (gap_seen_mid) begin
                            n_gap_seen = 1'b0;
                            n_next_ch  = '0;
                            n_in_frame = 1'b1;
                        end
                    end else if ((gap_inc < r_min_pulse) || (gap_inc > r_max_pulse)) begin
                        n_in_frame = 1'b0;
                    end else if (r_next_ch < CH_FULL) begin
                        store_we  = 1'b1;
                        n_next_ch = r_next_ch + CH_W'(1);
                    end
                    n_gap_count = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_count <= '0;
            r_ms_count  <= '0;
            r_in_frame  <= 1'b0;
            r_gap_seen  <= 1'b0;
            r_next_ch   <= '0;
            r_lock      <= 1'b0;
        end else begin
            r_gap_count <= n_gap_count;
            r_ms_count  <= n_ms_count;
            r_in_frame  <= n_in_frame;
            r_gap_seen  <= n_gap_seen;
            r_next_ch   <= n_next_ch;
            r_lock      <= n_lock;
        end
    end

    // Channel slot store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_store[i] <= '0;
            end
        end else if (store_we) begin
            r_store[r_next_ch[IDX_W-1:0]] <= gap_inc;
        end
    end

    // Burst index and captured channel count
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && report && !stop) begin
            r_frame_ch <= r_next_ch;
            r_idx      <= '0;
        end else if (i_cmd.load_slot) begin
            r_idx      <= r_idx + IDX_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_slot || i_cmd.load_stop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_slot) begin
            r_out.kind           <= KIND_CHANNEL;
            r_out.channel_index  <= 3'(r_idx);
            r_out.channel_value  <= r_store[r_idx];
            r_out.frame_channels <= 4'(r_frame_ch);
            r_out.locked         <= r_lock;
            r_out.last           <= (r_idx == IDX_LAST);
        end else if (i_cmd.load_stop) begin
            r_out.kind           <= KIND_STOP;
            r_out.channel_index  <= '0;
            r_out.channel_value  <= '0;
            r_out.frame_channels <= '0;
            r_out.locked         <= r_lock;
            r_out.last           <= 1'b1;
        end
    end

    assign o_status.item_stop   = stop;
    assign o_status.item_report = report;
    assign o_status.out_free    = !r_out_valid || !i_out_stall;
    assign o_status.idx_last    = (r_idx == IDX_LAST);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* sv/ppm_frame_decoder.sv */
// A tick that causes no result is taken without a stall, so the decoder keeps pace with one
// timer tick per clock while no report or stop is in progress. When a frame completes, the
// tick that closes it starts a report of NUM_CHANNELS results, moved out through the single
// output register one per cycle while the output side does not stall; input is stalled
// until the last result is loaded. A timeout stalls input until the stop result is loaded,
// which waits out output stalls; then every request is accepted and dropped until reset. The
// slot store clears at reset, with no clearing pass. The configuration port is always ready.
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// Pulse-position frame decoder: timer ticks in, channel periods per frame out.
// ----------------------------------------------------------------------------
module ppm_frame_decoder
    import ppmfd_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    ppmfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ppmfd_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
